@@ rtl/prpb_pkg.sv @@
// Shared constants, types and register codes for the PRP list builder.
package prpb_pkg;

    localparam int ADDR_W     = 64;
    localparam int SECS_W     = 17;
    localparam int BYTES_W    = 25;
    localparam int SHIFT_W    = 4;
    localparam int IDX_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 25;

    localparam int PAGE_BYTES       = 4096;
    localparam int LIST_ENTRIES     = 64;
    localparam int ENTRIES_PER_PAGE = 512;

    localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
    localparam int FIRST_W      = PAGE_SHIFT + 1;
    localparam int SLOT_W       = $clog2(ENTRIES_PER_PAGE);
    localparam int BYTES_FULL_W = SECS_W + (1 << SHIFT_W) - 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ADDR_W-1:0]  PAGE_ADDR  = ADDR_W'(PAGE_BYTES);
    localparam logic [BYTES_W-1:0] PAGE_REM   = BYTES_W'(PAGE_BYTES);
    localparam logic [FIRST_W-1:0] PAGE_FIRST = FIRST_W'(PAGE_BYTES);
    localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(LIST_ENTRIES - 1);
    localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(ENTRIES_PER_PAGE - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_SHIFT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_XFER     = CFG_IDX_W'(1);

    localparam logic [SHIFT_W-1:0] SECTOR_SHIFT_RST = SHIFT_W'(9);
    localparam logic [BYTES_W-1:0] MAX_XFER_RST     = BYTES_W'(131072);

    typedef struct packed {
        logic [ADDR_W-1:0]  paddr;
        logic [ADDR_W-1:0]  list_addr;
        logic [SECS_W-1:0]  secs;
        logic [BYTES_W-1:0] bytes;
        logic [BYTES_W-1:0] remains;
    } prp_job_t;

endpackage

@@ rtl/prpb_front.sv @@
// Front end: configuration registers, request intake, clamp and list sizing.
module prpb_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [prpb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prpb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [prpb_pkg::ADDR_W-1:0]       s_buf_addr,
    input  logic [prpb_pkg::SECS_W-1:0]       s_sector_count,
    input  logic [prpb_pkg::ADDR_W-1:0]       s_list_addr,
    output logic                              q_push,
    output prpb_pkg::prp_job_t                q_wdata,
    input  logic                              q_full
);

    logic [prpb_pkg::SHIFT_W-1:0] sector_shift_reg;
    logic [prpb_pkg::BYTES_W-1:0] max_xfer_reg;

    logic                          hold_valid_reg;
    logic [prpb_pkg::ADDR_W-1:0]   buf_reg;
    logic [prpb_pkg::ADDR_W-1:0]   list_reg;
    logic [prpb_pkg::SECS_W-1:0]   secs_reg;

    logic [prpb_pkg::BYTES_W-1:0]      limit;
    logic [prpb_pkg::SECS_W-1:0]       secs_next;
    logic [prpb_pkg::BYTES_FULL_W-1:0] bytes_full;
    logic [prpb_pkg::BYTES_W-1:0]      bytes;
    logic [prpb_pkg::FIRST_W-1:0]      first;
    logic [prpb_pkg::BYTES_W-1:0]      first_ext;
    logic [prpb_pkg::BYTES_W-1:0]      rem_raw;
    logic [prpb_pkg::BYTES_W-1:0]      remains;
    logic                              accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sector_shift_reg <= prpb_pkg::SECTOR_SHIFT_RST;
            max_xfer_reg     <= prpb_pkg::MAX_XFER_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                prpb_pkg::CFG_SECTOR_SHIFT: begin
                    sector_shift_reg <= cfg_wdata[prpb_pkg::SHIFT_W-1:0];
                end
                prpb_pkg::CFG_MAX_XFER: begin
                    max_xfer_reg <= cfg_wdata[prpb_pkg::BYTES_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp the sector count to the largest transfer.
    always_comb begin
        limit = max_xfer_reg >> sector_shift_reg;
        if (prpb_pkg::BYTES_W'(s_sector_count) < limit) begin
            secs_next = s_sector_count;
        end else begin
            secs_next = limit[prpb_pkg::SECS_W-1:0];
        end
    end

    assign q_push  = hold_valid_reg && !q_full;
    assign s_ready = !hold_valid_reg || q_push;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (accept) begin
            hold_valid_reg <= 1'b1;
        end else if (q_push) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            buf_reg  <= s_buf_addr;
            list_reg <= s_list_addr;
            secs_reg <= secs_next;
        end
    end

    // First PRP covers up to the page boundary; PRP2 covers one more page.
    always_comb begin
        bytes_full = prpb_pkg::BYTES_FULL_W'(secs_reg) << sector_shift_reg;
        bytes      = bytes_full[prpb_pkg::BYTES_W-1:0];
        first      = prpb_pkg::PAGE_FIRST - {1'b0, buf_reg[prpb_pkg::PAGE_SHIFT-1:0]};
        first_ext  = prpb_pkg::BYTES_W'(first);
        rem_raw    = (bytes >= first_ext) ? (bytes - first_ext) : '0;
        remains    = (rem_raw > prpb_pkg::PAGE_REM) ? rem_raw : '0;

        q_wdata.paddr     = buf_reg + prpb_pkg::ADDR_W'(first);
        q_wdata.list_addr = list_reg;
        q_wdata.secs      = secs_reg;
        q_wdata.bytes     = bytes;
        q_wdata.remains   = remains;
    end

endmodule

@@ rtl/prpb_queue.sv @@
// Short job queue between the front end and the list sequencer.
module prpb_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  prpb_pkg::prp_job_t wdata,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output prpb_pkg::prp_job_t rdata
);

    prpb_pkg::prp_job_t mem [prpb_pkg::QUEUE_DEPTH];

    logic [prpb_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [prpb_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [prpb_pkg::QCNT_W-1:0] count_reg;

    assign full      = (count_reg == prpb_pkg::QCNT_W'(prpb_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == prpb_pkg::QPTR_W'(prpb_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == prpb_pkg::QPTR_W'(prpb_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

@@ rtl/prpb_back.sv @@
// Back end: walks one job and emits PRP list entries into the output register.
module prpb_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    input  prpb_pkg::prp_job_t             q_rdata,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_entry_valid,
    output logic [prpb_pkg::ADDR_W-1:0]    m_entry_addr,
    output logic [prpb_pkg::IDX_W-1:0]     m_entry_index,
    output logic                           m_is_link,
    output logic [prpb_pkg::SECS_W-1:0]    m_sectors_done,
    output logic [prpb_pkg::BYTES_W-1:0]   m_bytes_done,
    output logic                           m_overflow,
    output logic                           m_last
);

    typedef enum logic {ST_IDLE, ST_RUN} state_t;

    state_t                        state_reg, state_next;
    logic [prpb_pkg::ADDR_W-1:0]   paddr_reg, paddr_next;
    logic [prpb_pkg::ADDR_W-1:0]   link_reg, link_next;
    logic [prpb_pkg::BYTES_W-1:0]  remains_reg, remains_next;
    logic [prpb_pkg::IDX_W-1:0]    idx_reg, idx_next;
    logic [prpb_pkg::SLOT_W-1:0]   slot_reg, slot_next;
    logic [prpb_pkg::SECS_W-1:0]   secs_reg, secs_next;
    logic [prpb_pkg::BYTES_W-1:0]  bytes_reg, bytes_next;

    logic                          m_valid_reg, m_valid_next;
    logic                          ev_reg, ev_next;
    logic [prpb_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    logic [prpb_pkg::IDX_W-1:0]    oidx_reg, oidx_next;
    logic                          link_out_reg, link_out_next;
    logic [prpb_pkg::SECS_W-1:0]   osecs_reg, osecs_next;
    logic [prpb_pkg::BYTES_W-1:0]  obytes_reg, obytes_next;
    logic                          ovf_reg, ovf_next;
    logic                          last_reg, last_next;

    logic                          out_free;
    logic                          take_link;
    logic [prpb_pkg::BYTES_W-1:0]  rem_step;
    logic                          done;

    assign out_free = !m_valid_reg || m_ready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid && out_free;

    always_comb begin
        take_link = (slot_reg == prpb_pkg::LAST_SLOT) && (remains_reg > prpb_pkg::PAGE_REM);
        if (take_link) begin
            rem_step = remains_reg;
        end else if (remains_reg < prpb_pkg::PAGE_REM) begin
            rem_step = '0;
        end else begin
            rem_step = remains_reg - prpb_pkg::PAGE_REM;
        end
        done = (rem_step == '0) || (idx_reg == prpb_pkg::LAST_IDX);

        state_next    = state_reg;
        paddr_next    = paddr_reg;
        link_next     = link_reg;
        remains_next  = remains_reg;
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        secs_next     = secs_reg;
        bytes_next    = bytes_reg;
        m_valid_next  = out_free ? 1'b0 : m_valid_reg;
        ev_next       = ev_reg;
        addr_next     = addr_reg;
        oidx_next     = oidx_reg;
        link_out_next = link_out_reg;
        osecs_next    = osecs_reg;
        obytes_next   = obytes_reg;
        ovf_next      = ovf_reg;
        last_next     = last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_pop) begin
                    secs_next    = q_rdata.secs;
                    bytes_next   = q_rdata.bytes;
                    paddr_next   = q_rdata.paddr;
                    link_next    = q_rdata.list_addr + prpb_pkg::PAGE_ADDR;
                    remains_next = q_rdata.remains;
                    idx_next     = '0;
                    slot_next    = '0;
                    if (q_rdata.remains == '0) begin
                        // PRP1 and PRP2 cover it: one empty closing result.
                        m_valid_next  = 1'b1;
                        ev_next       = 1'b0;
                        addr_next     = '0;
                        oidx_next     = '0;
                        link_out_next = 1'b0;
                        osecs_next    = q_rdata.secs;
                        obytes_next   = q_rdata.bytes;
                        ovf_next      = 1'b0;
                        last_next     = 1'b1;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    ev_next       = 1'b1;
                    oidx_next     = idx_reg;
                    link_out_next = take_link;
                    osecs_next    = secs_reg;
                    obytes_next   = bytes_reg;
                    ovf_next      = done && (rem_step != '0);
                    last_next     = done;
                    if (take_link) begin
                        addr_next = link_reg;
                        link_next = link_reg + prpb_pkg::PAGE_ADDR;
                    end else begin
                        addr_next  = paddr_reg;
                        paddr_next = paddr_reg + prpb_pkg::PAGE_ADDR;
                    end
                    remains_next = rem_step;
                    idx_next     = idx_reg + 1'b1;
                    slot_next    = (slot_reg == prpb_pkg::LAST_SLOT) ? '0 : slot_reg + 1'b1;
                    if (done) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        paddr_reg    <= paddr_next;
        link_reg     <= link_next;
        remains_reg  <= remains_next;
        idx_reg      <= idx_next;
        slot_reg     <= slot_next;
        secs_reg     <= secs_next;
        bytes_reg    <= bytes_next;
        ev_reg       <= ev_next;
        addr_reg     <= addr_next;
        oidx_reg     <= oidx_next;
        link_out_reg <= link_out_next;
        osecs_reg    <= osecs_next;
        obytes_reg   <= obytes_next;
        ovf_reg      <= ovf_next;
        last_reg     <= last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_entry_valid  = ev_reg;
    assign m_entry_addr   = addr_reg;
    assign m_entry_index  = oidx_reg;
    assign m_is_link      = link_out_reg;
    assign m_sectors_done = osecs_reg;
    assign m_bytes_done   = obytes_reg;
    assign m_overflow     = ovf_reg;
    assign m_last         = last_reg;

endmodule

@@ rtl/nvme_prp_list_builder.sv @@
// Top level of the NVMe PRP list builder: front end, job queue and list sequencer.
// Path: an accepted request waits in the front-end register while the queue is full,
// then in the job queue until the sequencer loads it; a no-list result is registered
// on that load, and list entries in the run state whenever the output is free.
// The sequencer takes the next job only in idle, once the current one has ended.
// Reset (aresetn, synchronous, active low) empties queue and output, loads 9 and 131072.
module nvme_prp_list_builder (
    input  logic                              aclk,
    input  logic                              aresetn,

    // Configuration writes: index 0 is sector_shift, index 1 max_transfer_bytes.
    input  logic                              cfg_wr_en,
    input  logic [prpb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [prpb_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    // Transfer request channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [prpb_pkg::ADDR_W-1:0]       s_buf_addr,
    input  logic [prpb_pkg::SECS_W-1:0]       s_sector_count,
    input  logic [prpb_pkg::ADDR_W-1:0]       s_list_addr,

    // PRP list entry channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_entry_valid,
    output logic [prpb_pkg::ADDR_W-1:0]       m_entry_addr,
    output logic [prpb_pkg::IDX_W-1:0]        m_entry_index,
    output logic                              m_is_link,
    output logic [prpb_pkg::SECS_W-1:0]       m_sectors_done,
    output logic [prpb_pkg::BYTES_W-1:0]      m_bytes_done,
    output logic                              m_overflow,
    output logic                              m_last
);

    // Sized jobs handed from the front end to the sequencer.
    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    prpb_pkg::prp_job_t q_wdata;
    prpb_pkg::prp_job_t q_rdata;

    // Clamp the request, size the list and hold the job until the queue has room.
    prpb_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_buf_addr     (s_buf_addr),
        .s_sector_count (s_sector_count),
        .s_list_addr    (s_list_addr),
        .q_push         (q_push),
        .q_wdata        (q_wdata),
        .q_full         (q_full)
    );

    // Decouple intake from emission so each side stalls on its own.
    prpb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .rdata     (q_rdata)
    );

    // Walk each job: data pages in order, a link at the last slot of each list page.
    prpb_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_valid        (q_valid),
        .q_rdata        (q_rdata),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_entry_valid  (m_entry_valid),
        .m_entry_addr   (m_entry_addr),
        .m_entry_index  (m_entry_index),
        .m_is_link      (m_is_link),
        .m_sectors_done (m_sectors_done),
        .m_bytes_done   (m_bytes_done),
        .m_overflow     (m_overflow),
        .m_last         (m_last)
    );

endmodule

@@ sim/tb_nvme_prp_list_builder.sv @@
// Self-checking testbench for the NVMe PRP list builder.
module tb_nvme_prp_list_builder;
    import prpb_pkg::*;

    // Cycles the block may still need after its last result before a register write.
    localparam int SETTLE_TAIL   = 4;
    // Random requests per register setting, and number of settings.
    localparam int PHASE_REQS    = 60;
    localparam int PHASE_COUNT   = 7;
    // Long receiver hold-off: starts once this many requests went in.
    localparam int HOLD_AT       = 110;
    localparam int HOLD_CYCLES   = 400;

    typedef enum logic {
        ROW_WRITE_REG,
        ROW_REQUEST
    } row_kind_t;

    // One row of the directed table. Rows with fixed_exp set carry their
    // expected no-list result; all others go through the predictor.
    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [ADDR_W-1:0]    buf_a;
        logic [SECS_W-1:0]    cnt;
        logic [ADDR_W-1:0]    lst;
        logic                 fixed_exp;
        logic [SECS_W-1:0]    fixed_secs;
        logic [BYTES_W-1:0]   fixed_bytes;
    } stim_row_t;

    // One PRP list result as the block should emit it.
    typedef struct packed {
        logic                entry_valid;
        logic [ADDR_W-1:0]   addr;
        logic [IDX_W-1:0]    index;
        logic                is_link;
        logic [SECS_W-1:0]   sectors;
        logic [BYTES_W-1:0]  nbytes;
        logic                overflow;
        logic                last;
    } prp_entry_t;

    // Directed requests: run at reset settings first, then at the register extremes.
    localparam int DIRECTED_COUNT = 24;
    localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // zero sectors: no list, zero bytes
        '{ROW_REQUEST, '0, '0, 64'h0, 17'd0, 64'h0, 1'b1, 17'd0, 25'd0},
        // one page from an aligned buffer: first PRP covers it all
        '{ROW_REQUEST, '0, '0, 64'h0, 17'd8, 64'h1000, 1'b1, 17'd8, 25'd4096},
        // two pages: PRP2 covers the rest directly
        '{ROW_REQUEST, '0, '0, 64'h0, 17'd16, 64'h1000, 1'b1, 17'd16, 25'd8192},
        // one sector past two pages: smallest transfer that needs a list
        '{ROW_REQUEST, '0, '0, 64'h0, 17'd17, 64'h2000, 1'b0, '0, '0},
        '{ROW_REQUEST, '0, '0, 64'h800, 17'd16, 64'h3000, 1'b0, '0, '0},
        // clamp to the reset maximum, buffer at the top of the address space
        '{ROW_REQUEST, '0, '0, 64'hFFFF_FFFF_FFFF_FFFF, 17'd65536,
          64'hFFFF_FFFF_FFFF_F000, 1'b0, '0, '0},
        '{ROW_REQUEST, '0, '0, 64'hFFFF_FFFF_FFFF_F000, 17'h1FFFF,
          64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0, '0},
        '{ROW_REQUEST, '0, '0, 64'h123, 17'd1, 64'h0, 1'b1, 17'd1, 25'd512},
        '{ROW_REQUEST, '0, '0, 64'h5555_5555_5555_5555, 17'h0AAAA,
          64'hAAAA_AAAA_AAAA_A000, 1'b0, '0, '0},
        // largest in-range maximum: list runs out of slots
        '{ROW_WRITE_REG, CFG_MAX_XFER, 25'd16777216, 64'h0, '0, 64'h0, 1'b0, '0, '0},
        '{ROW_REQUEST, '0, '0, 64'h0, 17'd65536, 64'h10000, 1'b0, '0, '0},
        '{ROW_REQUEST, '0, '0, 64'hFFF, 17'h1FFFF, 64'h7000, 1'b0, '0, '0},
        // zero maximum: every request clamps to zero sectors
        '{ROW_WRITE_REG, CFG_MAX_XFER, 25'd0, 64'h0, '0, 64'h0, 1'b0, '0, '0},
        '{ROW_REQUEST, '0, '0, 64'h0, 17'h1FFFF, 64'h0, 1'b1, 17'd0, 25'd0},
        // all-ones data: shift takes 15 from the low nibble, maximum at full width
        '{ROW_WRITE_REG, CFG_SECTOR_SHIFT, 25'h1FF_FFFF, 64'h0, '0, 64'h0, 1'b0, '0, '0},
        '{ROW_WRITE_REG, CFG_MAX_XFER, 25'h1FF_FFFF, 64'h0, '0, 64'h0, 1'b0, '0, '0},
        '{ROW_REQUEST, '0, '0, 64'h0, 17'd1, 64'h8000, 1'b0, '0, '0},
        '{ROW_REQUEST, '0, '0, 64'h0, 17'h1FFFF, 64'h9000, 1'b0, '0, '0},
        // byte-sized sectors
        '{ROW_WRITE_REG, CFG_SECTOR_SHIFT, 25'd0, 64'h0, '0, 64'h0, 1'b0, '0, '0},
        '{ROW_REQUEST, '0, '0, 64'h10, 17'h1FFFF, 64'hA000, 1'b0, '0, '0},
        // smallest in-range maximum with 4 KiB sectors: one sector per command
        '{ROW_WRITE_REG, CFG_SECTOR_SHIFT, 25'd12, 64'h0, '0, 64'h0, 1'b0, '0, '0},
        '{ROW_WRITE_REG, CFG_MAX_XFER, 25'd4096, 64'h0, '0, 64'h0, 1'b0, '0, '0},
        '{ROW_REQUEST, '0, '0, 64'h0, 17'd5, 64'h0, 1'b1, 17'd1, 25'd4096},
        '{ROW_REQUEST, '0, '0, 64'hFFF, 17'd5, 64'h0, 1'b1, 17'd1, 25'd4096}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [ADDR_W-1:0]     s_buf_addr;
    logic [SECS_W-1:0]     s_sector_count;
    logic [ADDR_W-1:0]     s_list_addr;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_entry_valid;
    logic [ADDR_W-1:0]     m_entry_addr;
    logic [IDX_W-1:0]      m_entry_index;
    logic                  m_is_link;
    logic [SECS_W-1:0]     m_sectors_done;
    logic [BYTES_W-1:0]    m_bytes_done;
    logic                  m_overflow;
    logic                  m_last;

    // Mirror of the configuration registers, updated as each write lands.
    logic [SHIFT_W-1:0]    shift_mirror;
    logic [BYTES_W-1:0]    max_xfer_mirror;

    // Results still owed by the block, oldest first.
    prp_entry_t            pending_prp_entries [$];

    int requests_taken;
    int results_seen;
    int entries_seen;
    int overflows_seen;
    int reg_writes;
    int mismatch_count;

    nvme_prp_list_builder i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_buf_addr     (s_buf_addr),
        .s_sector_count (s_sector_count),
        .s_list_addr    (s_list_addr),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_entry_valid  (m_entry_valid),
        .m_entry_addr   (m_entry_addr),
        .m_entry_index  (m_entry_index),
        .m_is_link      (m_is_link),
        .m_sectors_done (m_sectors_done),
        .m_bytes_done   (m_bytes_done),
        .m_overflow     (m_overflow),
        .m_last         (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Work out every result one request causes and queue them in order.
    function automatic void build_prp_entries(input logic [ADDR_W-1:0] buf_a,
                                              input logic [SECS_W-1:0] cnt,
                                              input logic [ADDR_W-1:0] lst);
        logic [63:0] limit;
        logic [63:0] secs;
        logic [63:0] nbytes;
        logic [63:0] next_page;
        logic [63:0] page_addr;
        logic [63:0] first_span;
        logic [63:0] uncovered;
        logic [63:0] link_pages;
        prp_entry_t  e;
        int          slot;

        limit      = 64'(max_xfer_mirror) >> shift_mirror;
        secs       = (64'(cnt) < limit) ? 64'(cnt) : limit;
        nbytes     = secs << shift_mirror;
        next_page  = buf_a + PAGE_ADDR;
        page_addr  = next_page - (next_page % PAGE_ADDR);
        first_span = page_addr - buf_a;
        uncovered  = (nbytes >= first_span) ? nbytes - first_span : 64'd0;
        // PRP2 alone covers up to one more page
        if (uncovered <= PAGE_ADDR)
            uncovered = 64'd0;

        e         = '0;
        e.sectors = secs[SECS_W-1:0];
        e.nbytes  = nbytes[BYTES_W-1:0];
        if (uncovered == 64'd0) begin
            e.last = 1'b1;
            pending_prp_entries.push_back(e);
            return;
        end

        link_pages = 64'd0;
        slot       = 0;
        while (uncovered != 64'd0 && slot < LIST_ENTRIES) begin
            // queue the previous slot now that another one follows it
            if (slot != 0)
                pending_prp_entries.push_back(e);
            e.entry_valid = 1'b1;
            e.index       = IDX_W'(slot);
            if (slot % ENTRIES_PER_PAGE == ENTRIES_PER_PAGE - 1 && uncovered > PAGE_ADDR) begin
                link_pages = link_pages + 64'd1;
                e.addr     = lst + link_pages * PAGE_ADDR;
                e.is_link  = 1'b1;
            end else begin
                e.addr     = page_addr;
                e.is_link  = 1'b0;
                page_addr  = page_addr + PAGE_ADDR;
                uncovered  = uncovered - ((uncovered < PAGE_ADDR) ? uncovered : PAGE_ADDR);
            end
            slot++;
        end
        e.overflow = (uncovered != 64'd0);
        e.last     = 1'b1;
        pending_prp_entries.push_back(e);
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Sender gap: mostly none or short, now and then long.
    function automatic int tx_gap(input bit gapless);
        int r;

        r = $urandom_range(0, 99);
        if (gapless || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random request content, weighted toward page edges, address wrap and clamping.
    function automatic void random_request(output logic [ADDR_W-1:0] buf_a,
                                           output logic [SECS_W-1:0] cnt,
                                           output logic [ADDR_W-1:0] lst);
        int r;

        case ($urandom_range(0, 4))
            0: buf_a = {$urandom, $urandom} & ~64'hFFF;
            1: buf_a = ({$urandom, $urandom} & ~64'hFFF) | 64'(4095 - $urandom_range(0, 63));
            2: buf_a = {$urandom, $urandom};
            3: buf_a = ~64'($urandom_range(0, 16383));
            default: buf_a = 64'($urandom_range(0, 65535));
        endcase

        r = $urandom_range(0, 9);
        if (r <= 3)
            cnt = SECS_W'($urandom_range(1, 24));
        else if (r <= 5)
            cnt = SECS_W'($urandom_range(25, 600));
        else if (r <= 7)
            cnt = SECS_W'($urandom);
        else if (r == 8)
            case ($urandom_range(0, 2))
                0: cnt = '0;
                1: cnt = SECS_W'(65536);
                default: cnt = '1;
            endcase
        else
            cnt = SECS_W'($urandom_range(1, 65536));

        lst = {$urandom, $urandom};
        if ($urandom_range(0, 4) != 0)
            lst = lst & ~64'hFFF;
    endfunction

    // Offer one request, optionally after a gap, and hold it until taken.
    task automatic offer_request(input logic [ADDR_W-1:0] buf_a, input logic [SECS_W-1:0] cnt,
                                 input logic [ADDR_W-1:0] lst, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_buf_addr     <= buf_a;
        s_sector_count <= cnt;
        s_list_addr    <= lst;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        requests_taken++;
    endtask

    // Drop valid, wait for every owed result, then let the pipeline drain.
    task automatic settle_block();
        s_valid <= 1'b0;
        while (pending_prp_entries.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_TAIL) @(posedge aclk);
    endtask

    // One register write; the trailing cycle keeps write enable edges apart.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_SECTOR_SHIFT)
            shift_mirror = val[SHIFT_W-1:0];
        else
            max_xfer_mirror = val[BYTES_W-1:0];
        reg_writes++;
        @(posedge aclk);
    endtask

    // Main stimulus: reset, directed table, then random phases.
    initial begin : request_driver
        stim_row_t          row;
        prp_entry_t         fixed;
        logic [ADDR_W-1:0]  buf_a;
        logic [SECS_W-1:0]  cnt;
        logic [ADDR_W-1:0]  lst;
        logic [SHIFT_W-1:0] new_shift;
        logic [BYTES_W-1:0] new_max;
        bit                 gapless;

        aresetn         <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= '0;
        cfg_wdata       <= '0;
        s_valid         <= 1'b0;
        s_buf_addr      <= '0;
        s_sector_count  <= '0;
        s_list_addr     <= '0;
        shift_mirror    = SECTOR_SHIFT_RST;
        max_xfer_mirror = MAX_XFER_RST;
        requests_taken  = 0;
        reg_writes      = 0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table. Register rows wait for the block to go idle.
        for (int r = 0; r < DIRECTED_COUNT; r++) begin
            row = DIRECTED_ROWS[r];
            if (row.kind == ROW_WRITE_REG) begin
                settle_block();
                write_reg(row.reg_idx, row.reg_val);
            end else begin
                offer_request(row.buf_a, row.cnt, row.lst, tx_gap(1'b0));
                if (row.fixed_exp) begin
                    fixed         = '0;
                    fixed.sectors = row.fixed_secs;
                    fixed.nbytes  = row.fixed_bytes;
                    fixed.last    = 1'b1;
                    pending_prp_entries.push_back(fixed);
                end else begin
                    build_prp_entries(row.buf_a, row.cnt, row.lst);
                end
            end
        end

        // Random phases, each under its own register setting. Every phase starts
        // with the sender paused until all owed results have come back.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            case (phase)
                0: begin new_shift = SECTOR_SHIFT_RST; new_max = MAX_XFER_RST; end
                1: begin new_shift = 4'd12; new_max = 25'd16777216; end
                2: begin new_shift = 4'd9;  new_max = 25'd16777216; end
                3: begin
                    new_shift = SHIFT_W'($urandom_range(9, 12));
                    new_max   = BYTES_W'($urandom_range(4096, 16777216));
                end
                4: begin new_shift = 4'd10; new_max = 25'd4096; end
                5: begin
                    new_shift = SHIFT_W'($urandom_range(0, 15));
                    new_max   = BYTES_W'($urandom);
                end
                default: begin
                    new_shift = 4'd11;
                    new_max   = BYTES_W'($urandom_range(4096, 16777216));
                end
            endcase
            settle_block();
            // upper data bits are junk for the shift register
            write_reg(CFG_SECTOR_SHIFT, {21'($urandom), new_shift});
            write_reg(CFG_MAX_XFER, new_max);

            // one phase runs back to back with no sender gaps
            gapless = (phase == 2);
            for (int k = 0; k < PHASE_REQS; k++) begin
                random_request(buf_a, cnt, lst);
                offer_request(buf_a, cnt, lst, tx_gap(gapless));
                build_prp_entries(buf_a, cnt, lst);
            end
        end

        settle_block();
        repeat (20) @(posedge aclk);

        $display("Run summary: %0d requests over %0d register writes, %0d results checked",
                 requests_taken, reg_writes, results_seen);
        $display("  (%0d list entries, %0d overflowed lists, one %0d-cycle receiver hold-off).",
                 entries_seen, overflows_seen, HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Result side ready: random stalls, steady stretches, and one long hold-off
    // that lets the job queue fill and back-pressure the request side.
    initial begin : result_ready_driver
        int  stall_left;
        int  hold_left;
        int  steady_left;
        bit  hold_done;
        int  r;

        stall_left  = 0;
        hold_left   = 0;
        steady_left = 0;
        hold_done   = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (!hold_done && requests_taken >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if (steady_left > 0) begin
                    steady_left--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 4)
                        steady_left = $urandom_range(50, 200);
                    else if (r < 25)
                        stall_left = $urandom_range(1, 3);
                    else if (r < 28)
                        stall_left = $urandom_range(8, 24);
                end
            end
        end
    end

    // Compare every accepted result with the oldest owed one.
    initial begin
        results_seen   = 0;
        entries_seen   = 0;
        overflows_seen = 0;
        mismatch_count = 0;
    end

    always @(posedge aclk) begin : result_check
        prp_entry_t want;

        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (m_entry_valid)
                entries_seen++;
            if (m_overflow)
                overflows_seen++;
            if (pending_prp_entries.size() == 0) begin
                $error("result with nothing owed: entry_addr %0h, entry_index %0d, last %0b",
                       m_entry_addr, m_entry_index, m_last);
                mismatch_count++;
            end else begin
                want = pending_prp_entries.pop_front();
                check_field("entry_valid", 64'(want.entry_valid), 64'(m_entry_valid));
                check_field("entry_addr", want.addr, m_entry_addr);
                check_field("entry_index", 64'(want.index), 64'(m_entry_index));
                check_field("is_link", 64'(want.is_link), 64'(m_is_link));
                check_field("sectors_done", 64'(want.sectors), 64'(m_sectors_done));
                check_field("bytes_done", 64'(want.nbytes), 64'(m_bytes_done));
                check_field("overflow", 64'(want.overflow), 64'(m_overflow));
                check_field("last", 64'(want.last), 64'(m_last));
            end
        end
    end

    // Hard stop: several times the slowest legal run (every request at 64 entries,
    // each entry behind the longest receiver stall).
    initial begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
